@@ src/line_pixel_rasterizer_macros.svh @@
// Assertion macros shared by the line pixel rasterizer RTL.
// Needs a clk_i in the scope where a macro is used; LPR_ASSERT also needs an active-low rst_ni.
`ifndef LINE_PIXEL_RASTERIZER_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property that must also hold while reset is asserted.
`define LPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/lpr_pkg.sv @@
// Shared types and constants for the line pixel rasterizer.
// No dependencies; imported by line_pixel_rasterizer, its checker and its testbench.
package lpr_pkg;

  // Default geometry
  localparam int unsigned COORD_BITS_DEF = 8;
  localparam int unsigned ROW_TOP_DEF    = 159;

  // Fixed field widths on the ports
  localparam int unsigned IN_COORD_W = 8;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned IN_DATA_W  = 4 * IN_COORD_W;
  localparam int unsigned OUT_DATA_W = 3 * PIX_W;

  // Request kinds carried on tuser
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_ORIENTATION = 1'b0,
    CFG_PIXEL_COLOR = 1'b1
  } cfg_idx_e;

  // Walk direction flags; ymaj is the lowest bit
  typedef struct packed {
    logic ydn;
    logic xdn;
    logic ymaj;
  } step_flags_t;

  // One result pixel, column in the lowest bits
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] color;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] column;
  } pixel_t;

endpackage

@@ src/line_pixel_rasterizer.sv @@
// Bresenham line pixel generator: start requests load endpoints, advance
// requests step the walk. Holds the walk state, config and output buffering.
// Depends on lpr_pkg and line_pixel_rasterizer_macros.svh.
// Each pixel is registered in the output register, or in the skid entry on a stall.
// Throughput: one request per cycle when not stalled; the step logic is a single add/compare pass.
// An output register plus one skid entry keep s_axis_tready high until both hold pixels.
// Reset (async, active low): no line active, both output entries empty,
// orientation portrait, pixel color 0xFFFF.
`include "line_pixel_rasterizer_macros.svh"

module line_pixel_rasterizer
  import lpr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ROW_TOP    = ROW_TOP_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [PIX_W-1:0]      cfg_data_i,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: start_x [7:0], start_y [15:8], end_x [23:16], end_y [31:24]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: operation [0]
  input  logic                  s_axis_tuser,
  // Pixel stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: column [15:0], row [31:16], color [47:32]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 2;
  localparam logic [PIX_W-1:0] ROW_TOP_W = PIX_W'(ROW_TOP);

  // Configuration registers
  logic             orient_q;
  logic [PIX_W-1:0] color_q;

  // Walk state
  logic              active_q, active_d;
  logic [CB-1:0]     cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [CB-1:0]     stop_col_q, stop_row_q;
  logic [CB-1:0]     dmaj_q, dmin_q;
  logic [EW-1:0]     err_q, err_d;
  step_flags_t       flags_q;

  // Output register and skid entry
  logic   out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  pixel_t out_pix_q, out_pix_d, skid_pix_q, skid_pix_d;

  // Request decode
  logic    accept, produce, is_start;
  logic [CB-1:0] x1, y1, x2, y2;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_start = (op_e'(s_axis_tuser) == OP_START);
  assign produce  = accept && (is_start || active_q);
  assign x1 = CB'(s_axis_tdata[IN_COORD_W-1:0]);
  assign y1 = CB'(s_axis_tdata[2*IN_COORD_W-1:IN_COORD_W]);
  assign x2 = CB'(s_axis_tdata[3*IN_COORD_W-1:2*IN_COORD_W]);
  assign y2 = CB'(s_axis_tdata[4*IN_COORD_W-1:3*IN_COORD_W]);

  // Set up a new line from the endpoints
  logic [CB-1:0] dx, dy;
  logic [CB-1:0] ini_cur_col, ini_cur_row, ini_stop_col, ini_stop_row;
  logic [CB-1:0] ini_dmaj, ini_dmin;
  step_flags_t   ini_flags;

  always_comb begin
    dx = (x2 > x1) ? x2 - x1 : x1 - x2;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    ini_flags = '0;
    if (y1 == y2) begin
      ini_cur_col  = (x1 < x2) ? x1 : x2;
      ini_stop_col = (x1 < x2) ? x2 : x1;
      ini_cur_row  = y1;
      ini_stop_row = y1;
      ini_dmaj     = dx;
      ini_dmin     = '0;
    end else if (x1 == x2) begin
      ini_cur_row    = (y1 < y2) ? y1 : y2;
      ini_stop_row   = (y1 < y2) ? y2 : y1;
      ini_cur_col    = x1;
      ini_stop_col   = x1;
      ini_dmaj       = dy;
      ini_dmin       = '0;
      ini_flags.ymaj = 1'b1;
    end else begin
      ini_cur_col    = x1;
      ini_cur_row    = y1;
      ini_stop_col   = x2;
      ini_stop_row   = y2;
      ini_flags.xdn  = !(x2 > x1);
      ini_flags.ydn  = !(y2 > y1);
      ini_flags.ymaj = (dx < dy);
      ini_dmaj       = (dx < dy) ? dy : dx;
      ini_dmin       = (dx < dy) ? dx : dy;
    end
  end

  // Pick the state the pixel comes from
  logic [CB-1:0] sel_cur_col, sel_cur_row, sel_stop_col, sel_stop_row;
  logic [CB-1:0] sel_dmaj, sel_dmin;
  logic [EW-1:0] sel_err;
  step_flags_t   sel_flags;

  always_comb begin
    if (is_start) begin
      sel_cur_col  = ini_cur_col;
      sel_cur_row  = ini_cur_row;
      sel_stop_col = ini_stop_col;
      sel_stop_row = ini_stop_row;
      sel_dmaj     = ini_dmaj;
      sel_dmin     = ini_dmin;
      sel_flags    = ini_flags;
      sel_err      = -EW'(ini_dmaj >> 1);
    end else begin
      sel_cur_col  = cur_col_q;
      sel_cur_row  = cur_row_q;
      sel_stop_col = stop_col_q;
      sel_stop_row = stop_row_q;
      sel_dmaj     = dmaj_q;
      sel_dmin     = dmin_q;
      sel_flags    = flags_q;
      sel_err      = err_q;
    end
  end

  // One Bresenham step: emit the current pixel, advance the position
  logic          fin, minor_step;
  logic [EW-1:0] err_add;
  logic [CB-1:0] col_step, row_step;

  always_comb begin
    fin        = sel_flags.ymaj ? (sel_cur_row == sel_stop_row)
                                : (sel_cur_col == sel_stop_col);
    err_add    = sel_err + EW'(sel_dmin);
    minor_step = (sel_dmin != '0) && !err_add[EW-1];
    col_step   = sel_flags.xdn ? sel_cur_col - 1'b1 : sel_cur_col + 1'b1;
    row_step   = sel_flags.ydn ? sel_cur_row - 1'b1 : sel_cur_row + 1'b1;
    err_d      = minor_step ? err_add - EW'(sel_dmaj) : err_add;
    if (sel_flags.ymaj) begin
      cur_row_d = row_step;
      cur_col_d = minor_step ? col_step : sel_cur_col;
    end else begin
      cur_col_d = col_step;
      cur_row_d = minor_step ? row_step : sel_cur_row;
    end
    active_d = !fin;
  end

  // Map the pixel to physical addresses
  pixel_t new_pix;

  always_comb begin
    if (orient_q) begin
      new_pix.column = PIX_W'(sel_cur_row);
      new_pix.row    = ROW_TOP_W - PIX_W'(sel_cur_col);
    end else begin
      new_pix.column = PIX_W'(sel_cur_col);
      new_pix.row    = PIX_W'(sel_cur_row);
    end
    new_pix.color = color_q;
    new_pix.last  = fin;
  end

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= 1'b0;
      color_q  <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ORIENTATION: orient_q <= cfg_data_i[0];
        CFG_PIXEL_COLOR: color_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Walk state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      stop_col_q <= '0;
      stop_row_q <= '0;
      dmaj_q     <= '0;
      dmin_q     <= '0;
      err_q      <= '0;
      flags_q    <= '0;
    end else if (produce) begin
      active_q   <= active_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      stop_col_q <= sel_stop_col;
      stop_row_q <= sel_stop_row;
      dmaj_q     <= sel_dmaj;
      dmin_q     <= sel_dmin;
      err_q      <= err_d;
      flags_q    <= sel_flags;
    end
  end

  // Output register with one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_pix_d    = out_pix_q;
    skid_valid_d = skid_valid_q;
    skid_pix_d   = skid_pix_q;
    if (!out_valid_q || m_axis_tready) begin
      out_valid_d  = skid_valid_q || produce;
      out_pix_d    = skid_valid_q ? skid_pix_q : new_pix;
      skid_valid_d = 1'b0;
    end else if (produce) begin
      skid_valid_d = 1'b1;
      skid_pix_d   = new_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    skid_pix_q <= skid_pix_d;
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pix_q.color, out_pix_q.row, out_pix_q.column};
  assign m_axis_tlast  = out_pix_q.last;

  // Checks
  `LPR_ASSERT_ALWAYS(a_cfg_always_ready, cfg_ready_o, "config channel not ready")
  `LPR_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full with output empty")
  `LPR_ASSERT(a_last_ends_line, (produce && fin) |=> !active_q, "line still active after last pixel")
  `LPR_ASSERT(a_idle_advance_silent, (accept && !is_start && !active_q && !out_valid_q) |=> !m_axis_tvalid, "pixel from advance while idle")
  `LPR_ASSERT(a_err_not_positive, !active_q || err_q[EW-1] || (err_q == '0), "error term positive during walk")

endmodule

@@ verif/line_pixel_rasterizer_checker.sv @@
// Pixel stream checker for the line pixel rasterizer: follows the config and
// request channels, predicts every pixel and compares it with the pixel stream.
// Depends on lpr_pkg; instantiated by line_pixel_rasterizer_tb.
module line_pixel_rasterizer_checker
  import lpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic                  cfg_index_i,
  input  logic [PIX_W-1:0]      cfg_data_i,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [IN_DATA_W-1:0]  req_data_i,
  input  logic                  req_op_i,
  input  logic                  px_valid_i,
  input  logic                  px_ready_i,
  input  logic [OUT_DATA_W-1:0] px_data_i,
  input  logic                  px_last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam logic [PIX_W-1:0] ROW_TOP = PIX_W'(ROW_TOP_DEF);

  // Shadow of the config registers
  logic             landscape;
  logic [PIX_W-1:0] fg_color;

  // Shadow of the line walk
  logic        walking;
  logic [7:0]  cur_x, cur_y, end_x, end_y;
  logic [7:0]  d_major, d_minor;
  int          err;
  step_flags_t flags;

  // Pixels predicted but not yet seen on the stream
  pixel_t      expected_px[$];

  function automatic logic [7:0] step_coord(input logic [7:0] v, input logic down);
    return down ? v - 8'd1 : v + 8'd1;
  endfunction

  // Queue the current pixel, then step the walk or close the line
  task automatic emit_and_step();
    pixel_t px;
    logic   done;
    done = flags.ymaj ? (cur_y == end_y) : (cur_x == end_x);
    if (landscape) begin
      px.column = {8'h00, cur_y};
      px.row    = ROW_TOP - {8'h00, cur_x};
    end else begin
      px.column = {8'h00, cur_x};
      px.row    = {8'h00, cur_y};
    end
    px.color = fg_color;
    px.last  = done;
    expected_px.push_back(px);
    if (done) begin
      walking = 1'b0;
    end else begin
      err += int'(d_minor);
      if (flags.ymaj) begin
        cur_y = step_coord(cur_y, flags.ydn);
        if (d_minor != 8'd0 && err >= 0) begin
          cur_x = step_coord(cur_x, flags.xdn);
          err -= int'(d_major);
        end
      end else begin
        cur_x = step_coord(cur_x, flags.xdn);
        if (d_minor != 8'd0 && err >= 0) begin
          cur_y = step_coord(cur_y, flags.ydn);
          err -= int'(d_major);
        end
      end
    end
  endtask

  // Load a new line from its endpoints and emit its first pixel
  task automatic start_line(input logic [IN_DATA_W-1:0] d);
    logic [7:0] x1, y1, x2, y2, dx, dy;
    x1 = d[7:0];
    y1 = d[15:8];
    x2 = d[23:16];
    y2 = d[31:24];
    dx = (x2 > x1) ? x2 - x1 : x1 - x2;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    flags = '0;
    if (y1 == y2) begin
      cur_x   = (x1 < x2) ? x1 : x2;
      end_x   = (x1 < x2) ? x2 : x1;
      cur_y   = y1;
      end_y   = y1;
      d_major = dx;
      d_minor = 8'd0;
    end else if (x1 == x2) begin
      cur_y      = (y1 < y2) ? y1 : y2;
      end_y      = (y1 < y2) ? y2 : y1;
      cur_x      = x1;
      end_x      = x1;
      d_major    = dy;
      d_minor    = 8'd0;
      flags.ymaj = 1'b1;
    end else begin
      cur_x      = x1;
      cur_y      = y1;
      end_x      = x2;
      end_y      = y2;
      flags.xdn  = (x2 < x1);
      flags.ydn  = (y2 < y1);
      flags.ymaj = (dx < dy);
      d_major    = flags.ymaj ? dy : dx;
      d_minor    = flags.ymaj ? dx : dy;
    end
    err     = -int'(d_major >> 1);
    walking = 1'b1;
    emit_and_step();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, exp_px;
    if (!rst_ni) begin
      landscape    = 1'b0;
      fg_color     = 16'hFFFF;
      walking      = 1'b0;
      cur_x        = '0;
      cur_y        = '0;
      end_x        = '0;
      end_y        = '0;
      d_major      = '0;
      d_minor      = '0;
      err          = 0;
      flags        = '0;
      expected_px.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Compare each delivered pixel with the oldest prediction
      if (px_valid_i && px_ready_i) begin
        got = {px_last_i, px_data_i};
        if (expected_px.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] unexpected pixel col=%h row=%h color=%h last=%b",
                     $realtime, got.column, got.row, got.color, got.last);
        end else begin
          exp_px = expected_px.pop_front();
          if (got.column !== exp_px.column || got.row !== exp_px.row ||
              got.color !== exp_px.color || got.last !== exp_px.last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("[%0t] pixel mismatch: exp col=%h row=%h color=%h last=%b, got col=%h row=%h color=%h last=%b",
                       $realtime, exp_px.column, exp_px.row, exp_px.color, exp_px.last,
                       got.column, got.row, got.color, got.last);
          end
        end
      end
      // Track config writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ORIENTATION: landscape = cfg_data_i[0];
          CFG_PIXEL_COLOR: fg_color  = cfg_data_i;
          default: ;
        endcase
      end
      // Predict from each accepted request
      if (req_valid_i && req_ready_i) begin
        if (req_op_i == OP_START) begin
          start_line(req_data_i);
        end else if (walking) begin
          emit_and_step();
        end
      end
      pending_o = expected_px.size();
    end
  end

endmodule

@@ verif/line_pixel_rasterizer_tb.sv @@
// Testbench top for the line pixel rasterizer: clock, reset, config writes,
// request stimulus and pixel back-pressure. Depends on lpr_pkg, the RTL and
// line_pixel_rasterizer_checker, which predicts and compares the pixels.
module line_pixel_rasterizer_tb;
  import lpr_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 165;
  localparam int NUM_PHASES  = 6;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i   = CFG_ORIENTATION;
  logic [PIX_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_START;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int          fail_count;
  int          pending;
  int          cycles     = 0;
  int          burst_left = 0;
  int          hold_left  = 0;
  int          rx_tick    = 0;
  logic        hold_req   = 1'b0;
  rx_pattern_e rx_mode    = RX_LIGHT;

  line_pixel_rasterizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_pixel_rasterizer_checker pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_op_i     (s_axis_tuser),
    .px_valid_i   (m_axis_tvalid),
    .px_ready_i   (m_axis_tready),
    .px_data_i    (m_axis_tdata),
    .px_last_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Pixel receiver: long hold on request, otherwise the selected stall pattern
  always @(negedge clk_i) begin
    rx_tick++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:  m_axis_tready = 1'b1;
        RX_LIGHT: m_axis_tready = ($urandom_range(0, 3) != 0);
        RX_HEAVY: m_axis_tready = ($urandom_range(0, 3) == 0);
        default:  m_axis_tready = ((rx_tick % 7) < 4);
      endcase
    end
  end

  // Write one config register and wait for it to be taken
  task automatic cfg_write(input cfg_idx_e idx, input logic [PIX_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = PIX_W'($urandom);
  endtask

  // Offer one request; insert a random gap between bursts
  task automatic send_req(input op_e op, input logic [IN_DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = data;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // Start a line and follow it with a number of advance requests
  task automatic draw_line(input logic [7:0] x1, y1, x2, y2, input int advances);
    send_req(OP_START, {y2, x2, y1, x1});
    repeat (advances) send_req(OP_ADVANCE, $urandom);
  endtask

  // Drop valid and wait until every predicted pixel has been delivered
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int         sent;
    int         advances;
    logic [7:0] ax, ay, bx, by, dx, dy;
    logic       hold_done;
    logic [PIX_W-1:0] color;

    hold_done = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines under reset config
    send_req(OP_ADVANCE, $urandom);            // advance with no line: dropped
    draw_line(8'd7, 8'd7, 8'd7, 8'd7, 0);      // single point
    send_req(OP_ADVANCE, $urandom);            // idle again after the last pixel
    draw_line(8'd3, 8'd255, 8'd0, 8'd255, 3);  // horizontal, drawn right to left input
    draw_line(8'd255, 8'd2, 8'd255, 8'd0, 2);  // vertical, reversed endpoints
    draw_line(8'd0, 8'd0, 8'd2, 8'd2, 2);      // equal deltas walk x-major
    draw_line(8'd10, 8'd20, 8'd9, 8'd16, 4);   // steep, both axes step down
    draw_line(8'd0, 8'd0, 8'd255, 8'd255, 1);  // abandoned by the next start
    draw_line(8'd255, 8'd0, 8'd0, 8'd3, 2);    // shallow, x steps down, left open

    // Random phases, each with a config and receiver pattern set from its index
    for (int k = 0; k < NUM_PHASES; k++) begin
      drain();
      case (k)
        0:       color = 16'h0000;
        1:       color = 16'hFFFF;
        4:       color = 16'h0000;
        default: color = PIX_W'($urandom);
      endcase
      cfg_write(CFG_ORIENTATION, {15'h0000, k[0]});
      cfg_write(CFG_PIXEL_COLOR, color);
      rx_mode = rx_pattern_e'(k % 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        ax = 8'($urandom);
        ay = 8'($urandom);
        if ($urandom_range(0, 11) == 0) begin
          bx = 8'($urandom);
          by = 8'($urandom);
        end else begin
          bx = ax + 8'($urandom_range(0, 12)) - 8'd6;
          by = ay + 8'($urandom_range(0, 12)) - 8'd6;
          case ($urandom_range(0, 5))
            0:       by = ay;
            1:       bx = ax;
            default: ;
          endcase
        end
        dx = (bx > ax) ? bx - ax : ax - bx;
        dy = (by > ay) ? by - ay : ay - by;
        advances = (dx > dy) ? int'(dx) : int'(dy);
        case ($urandom_range(0, 9))
          0:       advances = $urandom_range(0, advances);     // cut short
          1:       advances = advances + $urandom_range(1, 3); // trailing noise
          default: ;
        endcase
        // Long receiver hold while the sender keeps offering requests
        if (k == 2 && !hold_done && sent > PHASE_ITEMS / 2) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
          burst_left = 40;
        end
        draw_line(ax, ay, bx, by, advances);
        sent += advances + 1;
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
